/* src/frf_pkg.sv */
// frf_pkg: shared types and constants for the farmland rectangle finder
// depends on nothing; imported by the top level, frf_front and frf_back
`timescale 1ns / 1ps
`default_nettype none

package frf_pkg;

    localparam int COORD_W    = 9;
    localparam int START_W    = 2 * COORD_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0]  CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET        = 10'd512;

    // per-pixel classification handed from front to back
    typedef struct packed {
        logic               pixel;
        logic               has_above;   // row above exists
        logic               ar_ok;       // column to the right is inside the row
        logic               left_ok;     // pixel to the left is in this row
        logic               last_row;
        logic               last_col;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_pix_info;

    typedef struct packed {
        logic [COORD_W-1:0] top_row;
        logic [COORD_W-1:0] left_col;
        logic [COORD_W-1:0] bottom_row;
        logic [COORD_W-1:0] right_col;
    } t_result;

endpackage

`default_nettype wire

/* src/farmland_rectangle_finder.sv */
// farmland_rectangle_finder: top level, classifier, queue and group tracker
// depends on frf_pkg, frf_front, frf_queue, frf_back
`timescale 1ns / 1ps
`default_nettype none

// Takes a binary image one pixel per request in raster order and reports the
// top-left and bottom-right corners of every all-ones rectangle. A pixel is
// taken every cycle while the queue is not full; a pixel that closes two groups
// holds the tracker until both results have entered the output register, and the
// four entry queue absorbs the difference. A pixel passes through the queue,
// then the tracker stage while the line store is read, then the output
// register. The line stores need no clearing after reset; the user must write
// frame_width and frame_height through the config port only while no pixel is
// in flight, and the block itself does not enforce this.
module farmland_rectangle_finder
    import frf_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire logic                  i_pixel,
    input  wire logic                  i_frame_start,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      logic [COORD_W-1:0]    o_top_row,
    output      logic [COORD_W-1:0]    o_left_col,
    output      logic [COORD_W-1:0]    o_bottom_row,
    output      logic [COORD_W-1:0]    o_right_col,
    output      logic                  o_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int IW = $bits(t_pix_info);
    localparam int QW = CW + IW;

    logic          full, push, q_valid, q_pop;
    logic [CW-1:0] f_addr, b_addr;
    t_pix_info     f_info, b_info;
    logic [QW-1:0] q_in, q_out;
    t_result       result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;

    frf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_full        (full),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_push        (push),
        .o_addr        (f_addr),
        .o_info        (f_info)
    );

    assign q_in = {f_addr, f_info};

    frf_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign b_addr = q_out[QW-1 -: CW];
    assign b_info = t_pix_info'(q_out[IW-1:0]);

    frf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_addr    (b_addr),
        .i_q_info    (b_info),
        .o_q_pop     (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result),
        .o_last      (o_last)
    );

    assign o_top_row    = result.top_row;
    assign o_left_col   = result.left_col;
    assign o_bottom_row = result.bottom_row;
    assign o_right_col  = result.right_col;

endmodule

`default_nettype wire

/* src/frf_ram.sv */
// frf_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module frf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic                                        i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/frf_front.sv */
// frf_front: configuration registers, raster position tracking and pixel classification
// depends on frf_pkg
`timescale 1ns / 1ps
`default_nettype none

module frf_front
    import frf_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]                              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                             i_cfg_data,
    input  wire logic                                              i_in_valid,
    input  wire logic                                              i_full,
    input  wire logic                                              i_pixel,
    input  wire logic                                              i_frame_start,
    output      logic                                              o_push,
    output      logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_addr,
    output      t_pix_info                                         o_info
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW0 = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                         $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int DW = (DW0 > CFG_DATA_W) ? DW0 : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_frame_width, r_frame_height;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;

    logic [DW-1:0] ew, eh, fw_ext, fh_ext;
    logic [DW-1:0] col_s, row_s, col_inc, row_inc, col_n, row_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_RESET;
            r_frame_height <= DIM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign fw_ext = DW'(r_frame_width);
    assign fh_ext = DW'(r_frame_height);

    // zero counts as one, anything above the maximum counts as the maximum
    assign ew = (fw_ext == '0) ? DW'(1) :
                (fw_ext > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : fw_ext;
    assign eh = (fh_ext == '0) ? DW'(1) :
                (fh_ext > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : fh_ext;

    always_comb begin
        col_s = i_frame_start ? '0 : DW'(r_col);
        row_s = i_frame_start ? '0 : DW'(r_row);
        // position left beyond a narrowed row or a shortened frame
        if (col_s >= ew) begin
            col_s = '0;
            row_s = row_s + DW'(1);
        end
        if (row_s >= eh) begin
            row_s = '0;
        end
        col_inc = col_s + DW'(1);
        row_inc = row_s + DW'(1);
        col_n   = col_inc;
        row_n   = row_s;
        if (col_inc >= ew) begin
            col_n = '0;
            row_n = (row_inc >= eh) ? '0 : row_inc;
        end
    end

    assign o_push = i_in_valid && !i_full;
    assign o_addr = CW'(col_s);

    always_comb begin
        o_info.pixel     = i_pixel;
        o_info.has_above = (row_s != '0);
        o_info.ar_ok     = (col_inc < ew);
        o_info.left_ok   = (col_s != '0);
        o_info.last_row  = (row_inc == eh);
        o_info.last_col  = (col_inc == ew);
        o_info.row       = COORD_W'(row_s);
        o_info.col       = COORD_W'(col_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= CW'(col_n);
            r_row <= RW'(row_n);
        end
    end

endmodule

`default_nettype wire

/* src/frf_queue.sv */
// frf_queue: small flop based fifo between the classifier and the group tracker
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module frf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output      logic             o_full,
    output      logic             o_valid,
    output      logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

/* src/frf_back.sv */
// frf_back: line store, group tracking and result output register
// depends on frf_pkg and frf_ram
`timescale 1ns / 1ps
`default_nettype none

module frf_back
    import frf_pkg::*;
#(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_q_valid,
    input  wire logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] i_q_addr,
    input  wire t_pix_info                                         i_q_info,
    output      logic                                              o_q_pop,
    input  wire logic                                              i_out_stall,
    output      logic                                              o_out_valid,
    output      t_result                                           o_result,
    output      logic                                              o_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic               r_b_valid;
    logic [CW-1:0]      r_addr;
    t_pix_info          r_info;
    logic               r_second;
    logic               r_left_pix;
    logic [START_W-1:0] r_left_start;
    logic               r_fwd_a, r_fwd_b, r_fwd_pix;
    logic [START_W-1:0] r_fwd_start;
    logic               r_out_valid, r_out_last;
    t_result            r_out;

    logic [START_W:0]   ram_a_q;
    logic               ram_b_q;
    logic [CW-1:0]      rd_addr_a, rd_addr_b;
    logic               bit_c, bit_c1;
    logic [START_W-1:0] start_above, start_new, here;
    logic               above, above_right, left;
    logic               e0, e1, e2, any, two;
    t_result            res0, res1, res2, first, cur;
    logic               cur_last, out_free, send, retire, pop;

    assign rd_addr_a = i_q_addr;
    assign rd_addr_b = i_q_addr + CW'(1);

    frf_ram #(.WIDTH(START_W + 1), .DEPTH(MAX_WIDTH)) u_line_a (
        .i_clk     (i_clk),
        .i_wr_en   (retire),
        .i_wr_addr (r_addr),
        .i_wr_data ({r_info.pixel, start_new}),
        .i_rd_en   (pop),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (ram_a_q)
    );

    // copy of the row bits so the right neighbor is read in the same cycle
    frf_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_line_b (
        .i_clk     (i_clk),
        .i_wr_en   (retire),
        .i_wr_addr (r_addr),
        .i_wr_data (r_info.pixel),
        .i_rd_en   (pop),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (ram_b_q)
    );

    // the pixel retiring now writes the entry that a popped pixel reads
    assign bit_c       = r_fwd_a ? r_fwd_pix   : ram_a_q[START_W];
    assign start_above = r_fwd_a ? r_fwd_start : ram_a_q[START_W-1:0];
    assign bit_c1      = r_fwd_b ? r_fwd_pix   : ram_b_q;

    assign above       = r_info.has_above && bit_c;
    assign above_right = r_info.has_above && r_info.ar_ok && bit_c1;
    assign left        = r_info.left_ok && r_left_pix;
    assign here        = {r_info.row, r_info.col};

    always_comb begin
        priority if (above) begin
            start_new = start_above;
        end else if (left) begin
            start_new = r_left_start;
        end else begin
            start_new = here;
        end
    end

    // group closing just above, group closing to the left on the last row,
    // group closing at this pixel in the bottom-right corner of the frame
    assign e0  = !r_info.pixel && above && !above_right;
    assign e1  = r_info.last_row && !r_info.pixel && left;
    assign e2  = r_info.pixel && r_info.last_row && r_info.last_col;
    assign any = e0 || e1 || e2;
    assign two = e0 && e1;

    always_comb begin
        res0 = '{top_row: start_above[START_W-1:COORD_W], left_col: start_above[COORD_W-1:0],
                 bottom_row: r_info.row - COORD_W'(1), right_col: r_info.col};
        res1 = '{top_row: r_left_start[START_W-1:COORD_W], left_col: r_left_start[COORD_W-1:0],
                 bottom_row: r_info.row, right_col: r_info.col - COORD_W'(1)};
        res2 = '{top_row: start_new[START_W-1:COORD_W], left_col: start_new[COORD_W-1:0],
                 bottom_row: r_info.row, right_col: r_info.col};
        priority if (e0) begin
            first = res0;
        end else if (e1) begin
            first = res1;
        end else begin
            first = res2;
        end
    end

    assign cur      = r_second ? res1 : first;
    assign cur_last = r_second || !two;
    assign out_free = !r_out_valid || !i_out_stall;
    assign send     = r_b_valid && any && out_free;
    assign retire   = r_b_valid && (!any || (send && cur_last));
    assign pop      = i_q_valid && (!r_b_valid || retire);
    assign o_q_pop  = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
            r_left_pix  <= 1'b0;
        end else begin
            if (pop) begin
                r_b_valid <= 1'b1;
            end else if (retire) begin
                r_b_valid <= 1'b0;
            end
            if (retire) begin
                r_second   <= 1'b0;
                r_left_pix <= r_info.pixel;
            end else if (send) begin
                r_second <= 1'b1;
            end
            if (send) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_addr      <= i_q_addr;
            r_info      <= i_q_info;
            r_fwd_a     <= retire && (r_addr == rd_addr_a);
            r_fwd_b     <= retire && (r_addr == rd_addr_b);
            r_fwd_pix   <= r_info.pixel;
            r_fwd_start <= start_new;
        end
        if (retire) begin
            r_left_start <= start_new;
        end
        if (send) begin
            r_out      <= cur;
            r_out_last <= cur_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_second_needs_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> r_b_valid)
        else $error("second result pending without a pixel in the tracker");

    a_pair_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last && !i_out_stall) |=> r_out_valid)
        else $error("second result of a pixel did not follow the first");
`endif

endmodule

`default_nettype wire

/* tb/sv/farmland_rectangle_finder_tb.sv */
`timescale 1ns / 1ps
// farmland_rectangle_finder_tb: self-checking bench for the farmland rectangle finder
// depends on frf_pkg and farmland_rectangle_finder; tracks groups with its own raster pass

module farmland_rectangle_finder_tb;
    import frf_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int MAX_DIM      = 512;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [COORD_W-1:0] top_row;
        logic [COORD_W-1:0] left_col;
        logic [COORD_W-1:0] bottom_row;
        logic [COORD_W-1:0] right_col;
        logic               last;
    } t_rect;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic                  i_pixel       = 1'b0;
    logic                  i_frame_start = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [COORD_W-1:0]    o_top_row;
    logic [COORD_W-1:0]    o_left_col;
    logic [COORD_W-1:0]    o_bottom_row;
    logic [COORD_W-1:0]    o_right_col;
    logic                  o_last;

    // tracker state, same shape as the block's line store
    logic [CFG_DATA_W-1:0] width_reg  = DIM_RESET;
    logic [CFG_DATA_W-1:0] height_reg = DIM_RESET;
    bit                    prev_bits [MAX_DIM];
    logic [START_W-1:0]    col_start [MAX_DIM];
    int                    row_pos    = 0;
    int                    col_pos    = 0;
    bit                    left_bit   = 1'b0;
    logic [START_W-1:0]    left_start = '0;
    t_rect                 closed_rects [$];

    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    int   sent_count      = 0;
    int   fail_count      = 0;
    int   cur_w           = MAX_DIM;
    int   cur_h           = MAX_DIM;
    bit   need_fs         = 1'b0;
    logic hold_on         = 1'b0;
    bit   land_map [MAX_DIM][MAX_DIM];
    event hold_kick;

    farmland_rectangle_finder #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_top_row     (o_top_row),
        .o_left_col    (o_left_col),
        .o_bottom_row  (o_bottom_row),
        .o_right_col   (o_right_col),
        .o_last        (o_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int eff_dim(input logic [CFG_DATA_W-1:0] v);
        if (v < 1) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic t_rect make_rect(input logic [START_W-1:0] start, input int br,
                                        input int bc);
        t_rect rc;
        rc.top_row    = start[START_W-1:COORD_W];
        rc.left_col   = start[COORD_W-1:0];
        rc.bottom_row = br[COORD_W-1:0];
        rc.right_col  = bc[COORD_W-1:0];
        rc.last       = 1'b0;
        return rc;
    endfunction

    function automatic void track_pixel(input bit p, input bit fs);
        int                 ew, eh, r, c;
        bit                 above, above_right, last_row;
        logic [START_W-1:0] start;
        t_rect              found [$];
        ew = eff_dim(width_reg);
        eh = eff_dim(height_reg);
        if (fs) begin
            row_pos  = 0;
            col_pos  = 0;
            left_bit = 1'b0;
        end
        // position may lie past a reduced width or height
        if (col_pos >= ew) begin
            col_pos  = 0;
            left_bit = 1'b0;
            row_pos++;
        end
        if (row_pos >= eh) row_pos = 0;
        r = row_pos;
        c = col_pos;
        last_row    = (r + 1 == eh);
        above       = 1'b0;
        above_right = 1'b0;
        if (r > 0) begin
            above = prev_bits[c];
            if (c + 1 < ew) above_right = prev_bits[c + 1];
        end
        start = '0;
        // group whose bottom-right corner sits just above
        if (!p && above && !above_right) found = {found, make_rect(col_start[c], r - 1, c)};
        // last row: group ending at the left neighbor
        if (last_row && !p && left_bit) found = {found, make_rect(left_start, r, c - 1)};
        if (p) begin
            if (above) start = col_start[c];
            else if (left_bit) start = left_start;
            else start = {r[COORD_W-1:0], c[COORD_W-1:0]};
            if (last_row && c + 1 == ew) found = {found, make_rect(start, r, c)};
        end
        prev_bits[c] = p;
        if (p) col_start[c] = start;
        left_bit   = p;
        left_start = start;
        col_pos    = c + 1;
        if (col_pos >= ew) begin
            col_pos  = 0;
            left_bit = 1'b0;
            row_pos  = r + 1;
            if (row_pos >= eh) row_pos = 0;
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[i]) closed_rects = {closed_rects, found[i]};
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    // result check, register and pixel tracking, receiver stall
    always @(posedge i_clk) begin
        t_rect want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (closed_rects.size() == 0) begin
                    note_failure($sformatf("unexpected rect (%0d,%0d)-(%0d,%0d) last %0b",
                        o_top_row, o_left_col, o_bottom_row, o_right_col, o_last));
                end else begin
                    want = closed_rects.pop_front();
                    if (o_top_row !== want.top_row || o_left_col !== want.left_col ||
                        o_bottom_row !== want.bottom_row || o_right_col !== want.right_col ||
                        o_last !== want.last)
                        note_failure($sformatf(
                            {"expected (%0d,%0d)-(%0d,%0d) last %0b, ",
                             "got (%0d,%0d)-(%0d,%0d) last %0b"},
                            want.top_row, want.left_col, want.bottom_row, want.right_col,
                            want.last, o_top_row, o_left_col, o_bottom_row, o_right_col,
                            o_last));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) width_reg = i_cfg_data;
                else if (i_cfg_index == CFG_FRAME_HEIGHT) height_reg = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) track_pixel(i_pixel, i_frame_start);
        end
        i_out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(hold_kick);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    task automatic send_pixel(input bit p, input bit fs);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_pixel       <= p;
        i_frame_start <= fs | need_fs;
        need_fs = 1'b0;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_bits(input int n, input logic [31:0] bits, input bit fs);
        for (int k = 0; k < n; k++) send_pixel(bits[n - 1 - k], fs && k == 0);
    endtask

    task automatic send_frame(input int w, input int h, input bit fs, input int npix);
        for (int k = 0; k < npix; k++) send_pixel(land_map[k / w][k % w], fs && k == 0);
        // a cut frame leaves groups open; the next pixel restarts the frame
        if (npix < w * h) need_fs = 1'b1;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (closed_rects.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        // a wider row would read line-store entries the row above never wrote
        if (eff_dim(w) > eff_dim(width_reg)) need_fs = 1'b1;
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        i_cfg_valid <= 1'b0;
        cur_w = eff_dim(w);
        cur_h = eff_dim(h);
    endtask

    // rectangles that never share an edge, or plain noise
    function automatic void build_map(input int w, input int h, input bit noisy);
        int rh, rw, r0, c0, density;
        bit clash;
        density = $urandom_range(80, 20);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                land_map[r][c] = noisy && ($urandom_range(99) < density);
        if (!noisy) begin
            repeat (w * h / 4 + 2) begin
                rh = $urandom_range((h < 4) ? h : 4, 1);
                rw = $urandom_range((w < 5) ? w : 5, 1);
                r0 = $urandom_range(h - rh);
                c0 = $urandom_range(w - rw);
                clash = 1'b0;
                // ring around the rectangle must be clear, corners excepted
                for (int r = r0 - 1; r <= r0 + rh; r++)
                    for (int c = c0 - 1; c <= c0 + rw; c++)
                        if (r >= 0 && r < h && c >= 0 && c < w && land_map[r][c] &&
                            !((r == r0 - 1 || r == r0 + rh) && (c == c0 - 1 || c == c0 + rw)))
                            clash = 1'b1;
                if (!clash)
                    for (int r = r0; r < r0 + rh; r++)
                        for (int c = c0; c < c0 + rw; c++) land_map[r][c] = 1'b1;
            end
        end
    endfunction

    task automatic test_reset_defaults();
        // 512 x 512 after reset: row zero, nothing can close yet
        send_bits(2, 32'b10, 1'b0);
    endtask

    task automatic test_single_pixel_frames();
        // width and height of zero act as one
        set_frame(0, 0);
        send_bits(3, 32'b101, 1'b1);
    endtask

    task automatic test_two_closings();
        // row 1 col 2 closes the group above and the one to its left
        set_frame(4, 2);
        send_bits(8, 32'b0010_1101, 1'b1);
    endtask

    task automatic test_frame_restart();
        set_frame(3, 2);
        send_bits(2, 32'b11, 1'b1);
        send_bits(6, 32'b110_000, 1'b1);
    endtask

    task automatic test_frame_wrap();
        send_bits(6, 32'b000_011, 1'b0);
    endtask

    task automatic test_midframe_resize();
        send_bits(4, 32'b0110, 1'b1);
        // height drops below the current row: next pixel lands in row 0
        set_frame(2, 1);
        send_bits(1, 32'b1, 1'b0);
    endtask

    task automatic test_extreme_sizes();
        set_frame(1023, 1);
        build_map(cur_w, cur_h, 1'b0);
        send_frame(cur_w, cur_h, 1'b1, cur_w * cur_h);
        // one column, tall frame: every pixel reads the one written just before
        set_frame(1, 1023);
        build_map(cur_w, 24, 1'b0);
        send_frame(cur_w, cur_h, 1'b1, 24);
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        set_frame(8, 1);
        -> hold_kick;
        repeat (10) begin
            build_map(cur_w, cur_h, 1'b1);
            send_frame(cur_w, cur_h, 1'b0, cur_w * cur_h);
        end
    endtask

    task automatic test_random(input int n_items, input int idle, input int stall);
        int base, w, h, npix;
        sender_idle_pct = idle;
        recv_stall_pct  = stall;
        base = sent_count;
        while (sent_count - base < n_items) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
            h = $urandom_range(10, 0);
            set_frame(w, h);
            repeat ($urandom_range(4, 1)) begin
                if (sent_count - base < n_items) begin
                    build_map(cur_w, cur_h, $urandom_range(99) < 25);
                    npix = cur_w * cur_h;
                    if ($urandom_range(99) < 10) npix = $urandom_range(npix, 1);
                    // keep the phase close to its item budget
                    if (npix > n_items - (sent_count - base))
                        npix = n_items - (sent_count - base);
                    send_frame(cur_w, cur_h, $urandom_range(1), npix);
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_single_pixel_frames();
        test_two_closings();
        test_frame_restart();
        test_frame_wrap();
        test_midframe_resize();
        test_extreme_sizes();
        test_backpressure();
        test_random(50, 0, 0);
        test_random(50, 71, 0);
        test_random(50, 0, 71);
        test_random(50, 32, 32);
        wait_idle();
        if (fail_count == 0 && closed_rects.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
